// File: rtl/core/csvtok_pkg.sv
// shared constants, types and control structs for the csv field tokenizer
package csvtok_pkg;

  // depth of the leading-blank hold buffer
  localparam int unsigned BLANK_HOLD_DEPTH = 16;
  // address width of the hold buffer and width of its fill count
  localparam int unsigned HOLD_AW = (BLANK_HOLD_DEPTH > 1) ? $clog2(BLANK_HOLD_DEPTH) : 1;
  localparam int unsigned HOLD_CW = $clog2(BLANK_HOLD_DEPTH + 1);

  // character codes
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // source of the next result written to the output register
  typedef enum logic [1:0] {
    SEL_HELD,
    SEL_MARK,
    SEL_BYTE
  } out_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic     accept;      // input transfer this cycle, latch the byte
    logic     hold_wr;     // append the input byte to the hold buffer
    logic     hold_clr;    // drop all held blanks
    logic     flush_step;  // one held blank goes out, advance read index
    logic     flush_end;   // last held blank goes out, empty the buffer
    logic     out_ld;      // load the output register
    out_sel_e out_sel;
    logic     mark_re;     // record end flag for a mark result
    logic     last;        // last result of the current input item
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_comma;
    logic is_quote;
    logic is_lf;
    logic is_cr;
    logic is_blank;
    logic hold_full;
    logic hold_any;
    logic flush_last;  // the held blank at the read index is the final one
    logic out_free;    // output register can take a result this cycle
  } dp_stat_t;

endpackage

// File: rtl/core/csv_field_tokenizer.sv
// top level of the streaming csv field tokenizer
//
// Input channel: one text byte per transfer on in_byte_i, or an end-of-input
// marker with end_of_input_i high. Output channel: one result per transfer,
// either a field data byte (has_byte_o) or a mark (field_end_o, record_end_o);
// last_of_run_o flags the final result caused by an input item.
// Unless held blanks go out first, the first result of an item is written to
// the output register with its input transfer when that register is free. An
// item that yields at most one result then leaves nothing pending, so text
// streams at a byte per cycle while the receiver does not stall. A stray byte
// after a closing quote yields a mark and a byte, and the input stalls until
// the byte has gone out. Held blanks precede the result; the hold buffer ram
// has a registered read port and gives out one entry per cycle unless stalled.
// The block takes a new item while its previous result still waits in the
// output register. When the receiver stalls, the output register holds its
// result and in_stall_o rises once the current item still has results left.
// Reset puts the block at the start of a record with the hold buffer empty;
// the hold buffer needs no clearing pass, only its fill count and read index are reset.
module csv_field_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       has_byte_o,
  output logic       field_end_o,
  output logic       record_end_o,
  output logic       last_of_run_o
);
  import csvtok_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // scan control
  csvtok_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .end_of_input_i(end_of_input_i),
    .stat_i        (stat),
    .cmd_o         (cmd)
  );

  // hold buffer and output register
  csvtok_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_byte_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_byte_o   (out_byte_o),
    .has_byte_o   (has_byte_o),
    .field_end_o  (field_end_o),
    .record_end_o (record_end_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

// File: rtl/core/csvtok_ram.sv
// generic single write port ram with one registered read port
module csvtok_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/csvtok_dp.sv
// datapath: byte classes, hold buffer with fill count, flush index, output register
module csvtok_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [7:0]           in_byte_i,
  input  csvtok_pkg::dp_cmd_t  cmd_i,
  output csvtok_pkg::dp_stat_t stat_o,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic [7:0]           out_byte_o,
  output logic                 has_byte_o,
  output logic                 field_end_o,
  output logic                 record_end_o,
  output logic                 last_of_run_o
);
  import csvtok_pkg::*;

  logic [HOLD_CW-1:0] count_q, count_d;
  logic [HOLD_AW-1:0] idx_q, idx_d;
  logic [7:0]         byte_q;
  logic [7:0]         held_rd;
  logic               out_valid_q, out_valid_d;
  logic [7:0]         out_byte_q, out_byte_d;
  logic               has_q, has_d, fe_q, fe_d, re_q, re_d, last_q;

  // character classes of the incoming byte
  assign stat_o.is_comma   = (in_byte_i == CH_COMMA);
  assign stat_o.is_quote   = (in_byte_i == CH_QUOTE);
  assign stat_o.is_lf      = (in_byte_i == CH_LF);
  assign stat_o.is_cr      = (in_byte_i == CH_CR);
  assign stat_o.is_blank   = (in_byte_i == CH_SP) || (in_byte_i == CH_TAB);
  assign stat_o.hold_full  = (count_q == HOLD_CW'(BLANK_HOLD_DEPTH));
  assign stat_o.hold_any   = (count_q != '0);
  assign stat_o.flush_last = ((HOLD_CW'(idx_q) + HOLD_CW'(1)) == count_q);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;

  // hold buffer fill count
  always_comb begin
    count_d = count_q;
    if (cmd_i.hold_clr || cmd_i.flush_end) begin
      count_d = '0;
    end else if (cmd_i.hold_wr) begin
      count_d = count_q + HOLD_CW'(1);
    end
  end

  // flush read index, ram address runs one step ahead of the data
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.flush_end) begin
      idx_d = '0;
    end else if (cmd_i.flush_step) begin
      idx_d = idx_q + HOLD_AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // held leading blanks
  csvtok_ram #(
    .WIDTH(8),
    .DEPTH(BLANK_HOLD_DEPTH)
  ) u_hold_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.hold_wr),
    .waddr_i(count_q[HOLD_AW-1:0]),
    .wdata_i(in_byte_i),
    .raddr_i(idx_d),
    .rdata_o(held_rd)
  );

  // byte of the item in work
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_byte_i;
    end
  end

  // next result payload
  always_comb begin
    out_byte_d = 8'h00;
    has_d      = 1'b0;
    fe_d       = 1'b0;
    re_d       = 1'b0;
    unique case (cmd_i.out_sel)
      SEL_HELD: begin
        out_byte_d = held_rd;
        has_d      = 1'b1;
      end
      SEL_MARK: begin
        fe_d = 1'b1;
        re_d = cmd_i.mark_re;
      end
      SEL_BYTE: begin
        out_byte_d = cmd_i.accept ? in_byte_i : byte_q;
        has_d      = 1'b1;
      end
      default: begin
        out_byte_d = 8'h00;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (cmd_i.out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_byte_q <= out_byte_d;
      has_q      <= has_d;
      fe_q       <= fe_d;
      re_q       <= re_d;
      last_q     <= cmd_i.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign has_byte_o    = has_q;
  assign field_end_o   = fe_q;
  assign record_end_o  = re_q;
  assign last_of_run_o = last_q;

endmodule

// File: rtl/core/csvtok_ctrl.sv
// controller: scan mode state machine and result sequencing
module csvtok_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 end_of_input_i,
  input  csvtok_pkg::dp_stat_t stat_i,
  output csvtok_pkg::dp_cmd_t  cmd_o
);
  import csvtok_pkg::*;

  // scan mode codes
  localparam logic [2:0] M_REC    = 3'd0;
  localparam logic [2:0] M_REC_CR = 3'd1;
  localparam logic [2:0] M_FSTART = 3'd2;
  localparam logic [2:0] M_UNQ    = 3'd3;
  localparam logic [2:0] M_QUOTED = 3'd4;
  localparam logic [2:0] M_QSEEN  = 3'd5;
  localparam logic [2:0] M_CLOSED = 3'd6;

  logic [2:0] mode_q, mode_d, n_mode;
  // pending results of the current item: held blanks, mark, data byte
  logic pf_q, pf_d, pm_q, pm_d, pre_q, pre_d, pb_q, pb_d;
  logic n_f, n_m, n_re, n_b, n_hwr, n_hclr;
  logic unq_c, close_c;
  logic accept;
  logic cur_f, cur_m, cur_re, cur_b;
  logic emit_ok;

  assign in_stall_o = pf_q || pm_q || pb_q;
  assign accept     = in_valid_i && !in_stall_o;

  // decode one input item into next mode and a result plan
  always_comb begin
    n_mode  = mode_q;
    n_f     = 1'b0;
    n_m     = 1'b0;
    n_re    = 1'b0;
    n_b     = 1'b0;
    n_hwr   = 1'b0;
    n_hclr  = 1'b0;
    unq_c   = 1'b0;
    close_c = 1'b0;
    if (end_of_input_i) begin
      n_m    = (mode_q == M_FSTART) || (mode_q == M_UNQ) || (mode_q == M_QUOTED) ||
               (mode_q == M_QSEEN) || (mode_q == M_CLOSED);
      n_re   = 1'b1;
      n_hclr = 1'b1;
      n_mode = M_REC;
    end else begin
      unique case (mode_q)
        M_FSTART: begin
          if (stat_i.is_quote) begin
            n_mode = M_QUOTED;
          end else begin
            unq_c = 1'b1;
          end
        end
        M_UNQ: begin
          unq_c = 1'b1;
        end
        M_QUOTED: begin
          if (stat_i.is_quote) begin
            n_mode = M_QSEEN;
          end else begin
            n_b = 1'b1;
          end
        end
        M_QSEEN: begin
          if (stat_i.is_quote) begin
            n_b    = 1'b1;
            n_mode = M_QUOTED;
          end else begin
            close_c = 1'b1;
          end
        end
        M_CLOSED: begin
          close_c = 1'b1;
        end
        default: begin
          // record start, also the unused code
          if (mode_q == M_REC_CR && stat_i.is_lf) begin
            n_mode = M_REC;
          end else if (stat_i.is_blank) begin
            if (!stat_i.hold_full) begin
              n_hwr  = 1'b1;
              n_mode = M_REC;
            end else begin
              n_f    = 1'b1;
              n_b    = 1'b1;
              n_mode = M_UNQ;
            end
          end else if (stat_i.is_lf) begin
            n_hclr = 1'b1;
            n_mode = M_REC;
          end else if (stat_i.is_cr) begin
            n_hclr = 1'b1;
            n_mode = M_REC_CR;
          end else if (stat_i.hold_any) begin
            n_f   = 1'b1;
            unq_c = 1'b1;
          end else if (stat_i.is_quote) begin
            n_mode = M_QUOTED;
          end else begin
            unq_c = 1'b1;
          end
        end
      endcase

      // after a closing quote
      if (close_c) begin
        if (stat_i.is_blank) begin
          n_mode = M_CLOSED;
        end else if (stat_i.is_comma || stat_i.is_lf || stat_i.is_cr) begin
          unq_c = 1'b1;
        end else begin
          // stray byte ends the field and opens the next one
          n_m = 1'b1;
          if (stat_i.is_quote) begin
            n_mode = M_QUOTED;
          end else begin
            n_b    = 1'b1;
            n_mode = M_UNQ;
          end
        end
      end

      // byte inside an unquoted field
      if (unq_c) begin
        if (stat_i.is_comma) begin
          n_m    = 1'b1;
          n_mode = M_FSTART;
        end else if (stat_i.is_lf) begin
          n_m    = 1'b1;
          n_re   = 1'b1;
          n_mode = M_REC;
        end else if (stat_i.is_cr) begin
          n_m    = 1'b1;
          n_re   = 1'b1;
          n_mode = M_REC_CR;
        end else begin
          n_b    = 1'b1;
          n_mode = M_UNQ;
        end
      end
    end
  end

  // plan in effect this cycle
  assign cur_f  = accept ? n_f  : pf_q;
  assign cur_m  = accept ? n_m  : pm_q;
  assign cur_re = accept ? n_re : pre_q;
  assign cur_b  = accept ? n_b  : pb_q;
  // held data needs its registered ram read before it goes out
  assign emit_ok = stat_i.out_free && (cur_f || cur_m || cur_b) && !(cur_f && accept);

  // result sequencing: held blanks, then mark, then data byte
  always_comb begin
    pf_d  = cur_f;
    pm_d  = cur_m;
    pre_d = cur_re;
    pb_d  = cur_b;
    cmd_o            = '0;
    cmd_o.out_sel    = SEL_BYTE;
    cmd_o.accept     = accept;
    cmd_o.hold_wr    = accept && n_hwr;
    cmd_o.hold_clr   = accept && n_hclr;
    if (emit_ok) begin
      cmd_o.out_ld = 1'b1;
      if (cur_f) begin
        cmd_o.out_sel    = SEL_HELD;
        cmd_o.flush_step = 1'b1;
        cmd_o.last       = 1'b0;
        if (stat_i.flush_last) begin
          cmd_o.flush_end = 1'b1;
          pf_d            = 1'b0;
        end
      end else if (cur_m) begin
        cmd_o.out_sel = SEL_MARK;
        cmd_o.mark_re = cur_re;
        cmd_o.last    = !cur_b;
        pm_d          = 1'b0;
      end else begin
        cmd_o.out_sel = SEL_BYTE;
        cmd_o.last    = 1'b1;
        pb_d          = 1'b0;
      end
    end
  end

  assign mode_d = accept ? n_mode : mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_REC;
      pf_q   <= 1'b0;
      pm_q   <= 1'b0;
      pre_q  <= 1'b0;
      pb_q   <= 1'b0;
    end else begin
      mode_q <= mode_d;
      pf_q   <= pf_d;
      pm_q   <= pm_d;
      pre_q  <= pre_d;
      pb_q   <= pb_d;
    end
  end

endmodule
